FILE: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define BBC_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off while reset is asserted.
`define BBC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/bbc_pkg.sv
// ----------------------------------------------------------------------------
// Buffer cache LRU package
// Shared types, codes and sizes of the buffer cache directory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bbc_pkg;

  localparam int NUM_BUFFERS = 32;
  localparam int BUF_W       = $clog2(NUM_BUFFERS);
  localparam int SLOT_W      = 5;
  localparam int DEV_W       = 8;
  localparam int BLK_W       = 32;
  localparam int REF_W       = 8;
  localparam int TAG_W       = DEV_W + BLK_W;

  localparam logic [REF_W-1:0] REF_MAX = {REF_W{1'b1}};

  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_READ    = 2'd0;
  localparam opcode_t OP_RELEASE = 2'd1;
  localparam opcode_t OP_WRITE   = 2'd2;
  localparam opcode_t OP_UNUSED  = 2'd3;

  typedef logic [1:0] disk_req_t;
  localparam disk_req_t REQ_NONE  = 2'd0;
  localparam disk_req_t REQ_READ  = 2'd1;
  localparam disk_req_t REQ_WRITE = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t STS_OK       = 2'd0;
  localparam status_t STS_NO_FREE  = 2'd1;
  localparam status_t STS_UNREF    = 2'd2;
  localparam status_t STS_OVERFLOW = 2'd3;

  typedef struct packed {
    opcode_t           opcode;
    logic [DEV_W-1:0]  device;
    logic [BLK_W-1:0]  block_number;
    logic [SLOT_W-1:0] buffer_index;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    disk_req_t         disk_request;
    status_t           status;
  } out_item_t;

  typedef enum logic [1:0] {
    K_READ,
    K_RELEASE,
    K_WRITE,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic              in_range;
    logic [DEV_W-1:0]  device;
    logic [BLK_W-1:0]  block_number;
    logic [BUF_W-1:0]  idx;
    logic [SLOT_W-1:0] raw_idx;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_EXEC,
    ST_FIND,
    ST_MOVE
  } state_t;

endpackage

`default_nettype wire

FILE: src/block_buffer_cache_lru_unit.sv
// Read: one rank-ordered tag memory read and compare per buffer; a release that
// brings the count to zero also finds the slot in the order and moves it to rank 0.
// Requests of every kind are handled one request at a time.
// Two-deep queues on each side. Synchronous active-low reset: empty directory,
// rank order equal to slot index, no clearing pass.
// ----------------------------------------------------------------------------
// Buffer cache LRU unit
// Block buffer directory with least-recently-released replacement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module block_buffer_cache_lru_unit import bbc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  in_item_t  in_item,
  output logic      in_full,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_res
);

  logic cmd_avail, cmd_pop;
  cmd_t cmd;

  bbc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .cmd_avail (cmd_avail),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  bbc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_avail (cmd_avail),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_res   (out_res)
  );

endmodule

`default_nettype wire

FILE: src/bbc_front.sv
// ----------------------------------------------------------------------------
// Buffer cache LRU front end
// Accepts request beats, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbc_front import bbc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  in_item_t in_item,
  output logic     in_full,
  output logic     cmd_avail,
  input  logic     cmd_pop,
  output cmd_t     cmd
);

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       cls;
  logic       push_ok, pop_ok;

  always_comb begin
    cls              = '0;
    cls.device       = in_item.device;
    cls.block_number = in_item.block_number;
    cls.raw_idx      = in_item.buffer_index;
    cls.idx          = BUF_W'(in_item.buffer_index);
    cls.in_range     = (int'(in_item.buffer_index) < NUM_BUFFERS);
    unique case (in_item.opcode)
      OP_READ:    cls.kind = K_READ;
      OP_RELEASE: cls.kind = K_RELEASE;
      OP_WRITE:   cls.kind = K_WRITE;
      default:    cls.kind = K_NOP;
    endcase
  end

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_avail = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = cmd_pop && cmd_avail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_ok) wp_r <= ~wp_r;
      if (pop_ok)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push_ok) - 2'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) q_r[wp_r] <= cls;
  end

endmodule

`default_nettype wire

FILE: src/bbc_back.sv
// ----------------------------------------------------------------------------
// Buffer cache LRU back end
// Walks the recency order for lookups, updates the directory and queues
// result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbc_back import bbc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_avail,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_res
);

  state_t state_r, state_nxt;
  cmd_t   cmd_r;

  logic [BUF_W-1:0] order_r [NUM_BUFFERS];   // slot at each rank, rank 0 newest
  logic [REF_W-1:0] ref_r   [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] dval_r, tag_wr_r;
  logic [TAG_W-1:0] tag_mem [NUM_BUFFERS];

  logic [TAG_W-1:0] tag_q_r;
  logic             tag_wr_q_r;
  logic [BUF_W-1:0] k_r, cur_slot_r, rank_r;
  logic [BUF_W-1:0] hit_slot_r, vic_slot_r;
  logic             hit_found_r, vic_found_r;

  out_item_t  rq_r [2];
  logic       rq_wp_r, rq_rp_r;
  logic [1:0] rq_cnt_r;

  logic [BUF_W-1:0] ord_k, eslot, ref_addr;
  logic [REF_W-1:0] ref_cur;
  logic             tag_match, last_k;

  // control decisions
  logic             res_push, upd_ref, set_valid, tag_we, go_find;
  logic [REF_W-1:0] ref_new;
  out_item_t        res;

  assign ord_k  = order_r[k_r];
  assign last_k = (k_r == BUF_W'(NUM_BUFFERS - 1));

  always_comb begin
    if (cmd_r.kind == K_READ) begin
      if (hit_found_r)      eslot = hit_slot_r;
      else if (vic_found_r) eslot = vic_slot_r;
      else                  eslot = '0;
    end else begin
      eslot = cmd_r.idx;
    end
  end

  assign ref_addr  = (state_r == ST_CMP) ? cur_slot_r : eslot;
  assign ref_cur   = ref_r[ref_addr];
  // a never-written tag reads as zero
  assign tag_match = tag_wr_q_r ? (tag_q_r == {cmd_r.device, cmd_r.block_number})
                                : ({cmd_r.device, cmd_r.block_number} == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (cmd_pop) state_nxt = (cmd.kind == K_READ) ? ST_RD : ST_EXEC;
      ST_RD:   state_nxt = ST_CMP;
      ST_CMP:  state_nxt = last_k ? ST_EXEC : ST_RD;
      ST_EXEC: state_nxt = go_find ? ST_FIND : ST_IDLE;
      ST_FIND: if (ord_k == cmd_r.idx) state_nxt = ST_MOVE;
      ST_MOVE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    upd_ref   = 1'b0;
    set_valid = 1'b0;
    tag_we    = 1'b0;
    go_find   = 1'b0;
    ref_new   = ref_cur;
    res       = '0;
    unique case (state_r)
      ST_IDLE: cmd_pop = cmd_avail && (rq_cnt_r != 2'd2);
      ST_EXEC: begin
        res_push = 1'b1;
        unique case (cmd_r.kind)
          K_READ: begin
            res.slot = SLOT_W'(eslot);
            if (hit_found_r) begin
              if (ref_cur == REF_MAX) begin
                res.status = STS_OVERFLOW;
              end else begin
                upd_ref   = 1'b1;
                ref_new   = ref_cur + 1'b1;
                set_valid = 1'b1;
                res.disk_request = dval_r[eslot] ? REQ_NONE : REQ_READ;
              end
            end else if (vic_found_r) begin
              upd_ref   = 1'b1;
              ref_new   = REF_W'(1);
              set_valid = 1'b1;
              tag_we    = 1'b1;
              res.disk_request = REQ_READ;
            end else begin
              res.status = STS_NO_FREE;
            end
          end
          K_RELEASE: begin
            res.slot = cmd_r.raw_idx;
            if (!cmd_r.in_range || ref_cur == '0) begin
              res.status = STS_UNREF;
            end else begin
              upd_ref = 1'b1;
              ref_new = ref_cur - 1'b1;
              go_find = (ref_cur == REF_W'(1));
            end
          end
          K_WRITE: begin
            res.slot = cmd_r.raw_idx;
            res.disk_request = cmd_r.in_range ? REQ_WRITE : REQ_NONE;
          end
          default: res = '0;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dval_r      <= '0;
      tag_wr_r    <= '0;
      k_r         <= '0;
      hit_found_r <= 1'b0;
      vic_found_r <= 1'b0;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        order_r[i] <= BUF_W'(i);
        ref_r[i]   <= '0;
      end
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: begin
          k_r         <= '0;
          hit_found_r <= 1'b0;
          vic_found_r <= 1'b0;
        end
        ST_CMP: begin
          k_r <= k_r + 1'b1;
          if (!hit_found_r && tag_match) begin
            hit_found_r <= 1'b1;
            hit_slot_r  <= cur_slot_r;
          end
          // keep the last free slot seen: the least recent one
          if (ref_cur == '0) begin
            vic_found_r <= 1'b1;
            vic_slot_r  <= cur_slot_r;
          end
        end
        ST_EXEC: begin
          k_r <= '0;
          if (upd_ref)   ref_r[eslot]    <= ref_new;
          if (set_valid) dval_r[eslot]   <= 1'b1;
          if (tag_we)    tag_wr_r[eslot] <= 1'b1;
        end
        ST_FIND: begin
          k_r    <= k_r + 1'b1;
          rank_r <= k_r;
        end
        ST_MOVE: begin
          for (int i = 0; i < NUM_BUFFERS; i++) begin
            if (i == 0) order_r[i] <= cmd_r.idx;
            else if (i <= int'(rank_r)) order_r[i] <= order_r[i-1];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) cmd_r <= cmd;
    if (state_r == ST_RD) begin
      tag_q_r    <= tag_mem[ord_k];
      tag_wr_q_r <= tag_wr_r[ord_k];
      cur_slot_r <= ord_k;
    end
    if (tag_we) tag_mem[eslot] <= {cmd_r.device, cmd_r.block_number};
  end

  // result queue
  assign out_empty = (rq_cnt_r == 2'd0);
  assign out_res   = rq_r[rq_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wp_r  <= 1'b0;
      rq_rp_r  <= 1'b0;
      rq_cnt_r <= 2'd0;
    end else begin
      if (res_push)              rq_wp_r <= ~rq_wp_r;
      if (out_pop && !out_empty) rq_rp_r <= ~rq_rp_r;
      rq_cnt_r <= rq_cnt_r + 2'(res_push) - 2'(out_pop && !out_empty);
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) rq_r[rq_wp_r] <= res;
  end

endmodule

`default_nettype wire

FILE: src/bbc_checker.sv
// ----------------------------------------------------------------------------
// Buffer cache LRU checker
// Port-level assertions on the result beats, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bbc_checker import bbc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_empty,
  input logic      out_pop,
  input out_item_t out_res
);

  logic res_v, nofree_v, err_v;

  assign res_v    = !out_empty;
  assign nofree_v = res_v && (out_res.status == STS_NO_FREE);
  assign err_v    = res_v && (out_res.status != STS_OK);

  `BBC_ASSERT_NOW(a_nofree_slot0, clk, rst_n, nofree_v, out_res.slot == '0)
  `BBC_ASSERT_NOW(a_err_no_disk, clk, rst_n, err_v, out_res.disk_request == REQ_NONE)
  `BBC_ASSERT_NOW(a_req_code, clk, rst_n, res_v, out_res.disk_request <= REQ_WRITE)
  `BBC_ASSERT_NEXT(a_hold, clk, rst_n, res_v && !out_pop, !out_empty && $stable(out_res))

endmodule

bind block_buffer_cache_lru_unit bbc_checker u_chk (.*);

`default_nettype wire
